FILE: rtl/control_surface_sysex_parser_macros.svh
// ----------------------------------------------------------------------------
// Control-surface SysEx parser: assertion macros
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CONTROL_SURFACE_SYSEX_PARSER_MACROS_SVH
`define CONTROL_SURFACE_SYSEX_PARSER_MACROS_SVH

// same-cycle implication
`define CSP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Types, codes and reply tables of the control-surface SysEx parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  typedef struct packed {
    logic [7:0] port;
    logic [7:0] midi_byte;
  } csp_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] index;
    logic [7:0] value;
    logic       last;
  } csp_out_t;

  // event from parser to output stage
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_REPLY  = 2'd2;

  // reply selectors
  localparam logic [1:0] REPLY_QUERY    = 2'd0;
  localparam logic [1:0] REPLY_MC_QUERY = 2'd1;
  localparam logic [1:0] REPLY_HOST     = 2'd2;
  localparam logic [1:0] REPLY_VERSION  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    csp_out_t   res;
    logic [1:0] reply_sel;
    logic [7:0] reply_id;
  } csp_event_t;

  // actions
  localparam logic [2:0] ACT_REPLY        = 3'd0;
  localparam logic [2:0] ACT_MTC          = 3'd1;
  localparam logic [2:0] ACT_STATUS       = 3'd2;
  localparam logic [2:0] ACT_LCD_CURSOR   = 3'd3;
  localparam logic [2:0] ACT_LCD_CHAR     = 3'd4;
  localparam logic [2:0] ACT_METER_MODE   = 3'd5;
  localparam logic [2:0] ACT_GLOBAL_METER = 3'd6;

  // commands
  localparam logic [7:0] CMD_QUERY        = 8'h00;
  localparam logic [7:0] CMD_HOST_REPLY   = 8'h02;
  localparam logic [7:0] CMD_MTC          = 8'h10;
  localparam logic [7:0] CMD_STATUS       = 8'h11;
  localparam logic [7:0] CMD_LCD          = 8'h12;
  localparam logic [7:0] CMD_VERSION      = 8'h13;
  localparam logic [7:0] CMD_MC_QUERY     = 8'h1a;
  localparam logic [7:0] CMD_METER        = 8'h20;
  localparam logic [7:0] CMD_GLOBAL_METER = 8'h21;

  // config register indexes
  localparam logic [7:0] CFG_DEFAULT_PORT = 8'd0;
  localparam logic [7:0] CFG_EMULATION_ID = 8'd1;

  localparam logic [7:0] DEFAULT_PORT_RST = 8'd0;
  localparam logic [7:0] EMULATION_ID_RST = 8'h80;
  localparam logic [7:0] EMU_LEARN_A      = 8'h80;
  localparam logic [7:0] EMU_LEARN_B      = 8'h81;

  localparam logic [7:0] SYSEX_END     = 8'hf7;
  localparam logic [7:0] LCD_ROW_SPLIT = 8'd56;
  localparam logic [7:0] LCD_ROW_SHIFT = 8'd8;   // -56 + 0x40
  localparam logic [7:0] MTC_BASE      = 8'd9;
  localparam logic [7:0] STATUS_BASE   = 8'd1;
  localparam logic [6:0] METER_CHANNELS = 7'd8;

  localparam logic [2:0] HDR_LEN   = 3'd4;
  localparam logic [2:0] MATCH_LEN = 3'd5;
  localparam logic [4:0] PAYLOAD_START = 5'd5;

  localparam logic [7:0] HDR [4] = '{8'hf0, 8'h00, 8'h00, 8'h66};

  localparam logic [7:0] PL_QUERY [13] = '{
    8'h01, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h41, 8'h42, 8'h43, 8'h44};
  localparam logic [7:0] PL_MC_QUERY [2] = '{8'h1b, 8'h42};
  localparam logic [7:0] PL_HOST [9] = '{
    8'h03, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38};
  localparam logic [7:0] PL_VERSION [6] = '{8'h14, 8'h56, 8'h31, 8'h2e, 8'h34, 8'h32};

  // position of the closing F7 in each reply
  function automatic logic [4:0] reply_last_pos(input logic [1:0] sel);
    logic [4:0] p;
    p = 5'd0;
    unique case (sel)
      REPLY_QUERY:    p = 5'd18;
      REPLY_MC_QUERY: p = 5'd7;
      REPLY_HOST:     p = 5'd14;
      REPLY_VERSION:  p = 5'd11;
      default:        p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] payload_byte(input logic [1:0] sel, input logic [3:0] j);
    logic [7:0] v;
    v = 8'h00;
    unique case (sel)
      REPLY_QUERY:    v = (j < 4'd13) ? PL_QUERY[j] : 8'h00;
      REPLY_MC_QUERY: v = PL_MC_QUERY[j[0]];
      REPLY_HOST:     v = (j < 4'd9) ? PL_HOST[j] : 8'h00;
      REPLY_VERSION:  v = (j[2:0] < 3'd6) ? PL_VERSION[j[2:0]] : 8'h00;
      default:        v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic csp_out_t reply_item(input logic [1:0] sel, input logic [4:0] pos,
                                          input logic [7:0] id);
    csp_out_t   r;
    logic [4:0] j;
    r.action = ACT_REPLY;
    r.index  = 8'd0;
    r.last   = 1'b0;
    j        = pos - PAYLOAD_START;
    if (pos < {2'b00, HDR_LEN}) begin
      r.value = HDR[pos[1:0]];
    end else if (pos == {2'b00, HDR_LEN}) begin
      r.value = id;
    end else if (pos == reply_last_pos(sel)) begin
      r.value = SYSEX_END;
      r.last  = 1'b1;
    end else begin
      r.value = payload_byte(sel, j[3:0]);
    end
    return r;
  endfunction

endpackage

FILE: rtl/csp_parse.sv
// ----------------------------------------------------------------------------
// csp_parse
// Header matcher, ID learning, command decode and per-item actions.
// ----------------------------------------------------------------------------
`include "control_surface_sysex_parser_macros.svh"

module csp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata,
  input  logic                item_take,
  input  csp_pkg::csp_in_t    item,
  output csp_pkg::csp_event_t ev
);
  import csp_pkg::*;

  logic [7:0] default_port_r, default_port_nxt;
  logic [7:0] emulation_id_r, emulation_id_nxt;
  logic [2:0] header_count_r, header_count_nxt;
  logic       in_msg_r, in_msg_nxt;
  logic       cmd_seen_r, cmd_seen_nxt;
  logic [7:0] cmd_code_r, cmd_code_nxt;
  logic       lcd_seen_r, lcd_seen_nxt;
  logic       mch_seen_r, mch_seen_nxt;
  logic       mmode_seen_r, mmode_seen_nxt;
  logic [6:0] meter_ch_r, meter_ch_nxt;
  logic [7:0] mtc_pos_r, mtc_pos_nxt;
  logic [7:0] status_pos_r, status_pos_nxt;
  logic [7:0] learned_id_r, learned_id_nxt;

  logic [7:0] b;
  logic [7:0] learned_v;
  logic [7:0] dev_id;
  logic       mismatch;
  logic       learnable;

  function automatic logic [7:0] device_id(input logic [7:0] emu, input logic [7:0] lid);
    logic [7:0] d;
    d = 8'd0;
    if (!emu[7]) d = emu;
    else if (emu == EMU_LEARN_A || emu == EMU_LEARN_B) d = lid;
    return d;
  endfunction

  assign b = item.midi_byte;

  always_comb begin
    default_port_nxt = default_port_r;
    emulation_id_nxt = emulation_id_r;
    if (cfg_we) begin
      if (cfg_idx == CFG_DEFAULT_PORT) default_port_nxt = cfg_wdata;
      if (cfg_idx == CFG_EMULATION_ID) emulation_id_nxt = cfg_wdata;
    end
  end

  always_comb begin
    header_count_nxt = header_count_r;
    in_msg_nxt       = in_msg_r;
    cmd_seen_nxt     = cmd_seen_r;
    cmd_code_nxt     = cmd_code_r;
    lcd_seen_nxt     = lcd_seen_r;
    mch_seen_nxt     = mch_seen_r;
    mmode_seen_nxt   = mmode_seen_r;
    meter_ch_nxt     = meter_ch_r;
    mtc_pos_nxt      = mtc_pos_r;
    status_pos_nxt   = status_pos_r;
    learned_id_nxt   = learned_id_r;
    ev               = '0;
    ev.kind          = EV_NONE;
    learnable = (learned_id_r == 8'd0) && (header_count_r == HDR_LEN) &&
                ((emulation_id_r == EMU_LEARN_A && (b == 8'h10 || b == 8'h14)) ||
                 (emulation_id_r == EMU_LEARN_B && (b == 8'h11 || b == 8'h15)));
    learned_v = learnable ? b : learned_id_r;
    dev_id    = device_id(emulation_id_r, learned_v);
    mismatch  = (header_count_r < HDR_LEN) ? (b != HDR[header_count_r[1:0]])
                                           : (b != dev_id);

    if (item_take && !(in_msg_r && item.port != default_port_r)) begin
      if (!in_msg_r) begin
        learned_id_nxt = learned_v;
        if (mismatch) begin
          header_count_nxt = 3'd0;
          cmd_seen_nxt     = 1'b0;
          cmd_code_nxt     = 8'd0;
          lcd_seen_nxt     = 1'b0;
          mch_seen_nxt     = 1'b0;
          mmode_seen_nxt   = 1'b0;
        end else begin
          header_count_nxt = header_count_r + 3'd1;
          if (header_count_nxt >= MATCH_LEN) in_msg_nxt = 1'b1;
        end
      end else if (b[7]) begin
        if (b == SYSEX_END && cmd_seen_r) begin
          ev.reply_id = dev_id;
          unique case (cmd_code_r)
            CMD_QUERY: begin
              ev.kind = EV_REPLY;  ev.reply_sel = REPLY_QUERY;
            end
            CMD_MC_QUERY: begin
              ev.kind = EV_REPLY;  ev.reply_sel = REPLY_MC_QUERY;
            end
            CMD_HOST_REPLY: begin
              ev.kind = EV_REPLY;  ev.reply_sel = REPLY_HOST;
            end
            CMD_VERSION: begin
              ev.kind = EV_REPLY;  ev.reply_sel = REPLY_VERSION;
            end
            default: ev.kind = EV_NONE;
          endcase
        end
        header_count_nxt = 3'd0;
        in_msg_nxt       = 1'b0;
        cmd_seen_nxt     = 1'b0;
        cmd_code_nxt     = 8'd0;
        lcd_seen_nxt     = 1'b0;
        mch_seen_nxt     = 1'b0;
        mmode_seen_nxt   = 1'b0;
      end else if (!cmd_seen_r) begin
        cmd_seen_nxt = 1'b1;
        cmd_code_nxt = b;
        unique case (b)
          CMD_MTC:    mtc_pos_nxt = 8'd0;
          CMD_STATUS: status_pos_nxt = 8'd0;
          CMD_QUERY, CMD_MC_QUERY, CMD_HOST_REPLY, CMD_LCD,
          CMD_VERSION, CMD_METER, CMD_GLOBAL_METER: ;
          default: begin
            header_count_nxt = 3'd0;
            in_msg_nxt       = 1'b0;
            cmd_seen_nxt     = 1'b0;
            cmd_code_nxt     = 8'd0;
            lcd_seen_nxt     = 1'b0;
            mch_seen_nxt     = 1'b0;
            mmode_seen_nxt   = 1'b0;
          end
        endcase
      end else begin
        ev.res.value = b;
        unique case (cmd_code_r)
          CMD_MTC: begin
            ev.kind       = EV_SINGLE;
            ev.res.action = ACT_MTC;
            ev.res.index  = MTC_BASE - mtc_pos_r;
            mtc_pos_nxt   = mtc_pos_r + 8'd1;
          end
          CMD_STATUS: begin
            ev.kind        = EV_SINGLE;
            ev.res.action  = ACT_STATUS;
            ev.res.index   = STATUS_BASE - status_pos_r;
            status_pos_nxt = status_pos_r + 8'd1;
          end
          CMD_LCD: begin
            ev.kind = EV_SINGLE;
            if (!lcd_seen_r) begin
              lcd_seen_nxt  = 1'b1;
              ev.res.action = ACT_LCD_CURSOR;
              ev.res.value  = (b < LCD_ROW_SPLIT) ? b : b + LCD_ROW_SHIFT;
            end else begin
              ev.res.action = ACT_LCD_CHAR;
            end
          end
          CMD_METER: begin
            if (!mch_seen_r) begin
              mch_seen_nxt = 1'b1;
              meter_ch_nxt = b[6:0];
            end else if (!mmode_seen_r) begin
              mmode_seen_nxt = 1'b1;
              if (meter_ch_r < METER_CHANNELS) begin
                ev.kind       = EV_SINGLE;
                ev.res.action = ACT_METER_MODE;
                ev.res.index  = {1'b0, meter_ch_r};
              end
            end
          end
          CMD_GLOBAL_METER: begin
            if (!mmode_seen_r) begin
              mmode_seen_nxt = 1'b1;
              ev.kind        = EV_SINGLE;
              ev.res.action  = ACT_GLOBAL_METER;
            end
          end
          default: ev.kind = EV_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= DEFAULT_PORT_RST;
      emulation_id_r <= EMULATION_ID_RST;
      header_count_r <= 3'd0;
      in_msg_r       <= 1'b0;
      cmd_seen_r     <= 1'b0;
      cmd_code_r     <= 8'd0;
      lcd_seen_r     <= 1'b0;
      mch_seen_r     <= 1'b0;
      mmode_seen_r   <= 1'b0;
      meter_ch_r     <= 7'd0;
      mtc_pos_r      <= 8'd0;
      status_pos_r   <= 8'd0;
      learned_id_r   <= 8'd0;
    end else begin
      default_port_r <= default_port_nxt;
      emulation_id_r <= emulation_id_nxt;
      header_count_r <= header_count_nxt;
      in_msg_r       <= in_msg_nxt;
      cmd_seen_r     <= cmd_seen_nxt;
      cmd_code_r     <= cmd_code_nxt;
      lcd_seen_r     <= lcd_seen_nxt;
      mch_seen_r     <= mch_seen_nxt;
      mmode_seen_r   <= mmode_seen_nxt;
      meter_ch_r     <= meter_ch_nxt;
      mtc_pos_r      <= mtc_pos_nxt;
      status_pos_r   <= status_pos_nxt;
      learned_id_r   <= learned_id_nxt;
    end
  end

  `CSP_ASSERT_NOW(a_msg_full_hdr, in_msg_r, header_count_r == MATCH_LEN, "in message without full header")
  `CSP_ASSERT_NOW(a_idle_clean, !in_msg_r, !cmd_seen_r && !lcd_seen_r && !mmode_seen_r && header_count_r <= HDR_LEN, "stale message state while matching")
  `CSP_ASSERT_NEXT(a_learned_kept, learned_id_r != 8'd0, $stable(learned_id_r), "learned id changed")

endmodule

FILE: rtl/csp_out_seq.sv
// ----------------------------------------------------------------------------
// csp_out_seq
// Result register and reply sequencer; one item per cycle as out_ready allows.
// ----------------------------------------------------------------------------
`include "control_surface_sysex_parser_macros.svh"

module csp_out_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ev_take,
  input  csp_pkg::csp_event_t ev,
  output logic                take_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::csp_out_t   out_data
);
  import csp_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  csp_out_t   out_r, out_nxt;
  logic       busy_r, busy_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [7:0] id_r, id_nxt;
  logic       load_ok;

  assign load_ok = !out_valid_r || out_ready;
  assign take_ok = !busy_r && load_ok;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    sel_nxt       = sel_r;
    id_nxt        = id_r;
    if (busy_r && load_ok) begin
      out_valid_nxt = 1'b1;
      out_nxt       = reply_item(sel_r, pos_r, id_r);
      pos_nxt       = pos_r + 5'd1;
      if (pos_r == reply_last_pos(sel_r)) busy_nxt = 1'b0;
    end else if (ev_take) begin
      unique case (ev.kind)
        EV_SINGLE: begin
          out_valid_nxt = 1'b1;
          out_nxt       = ev.res;
        end
        EV_REPLY: begin
          out_valid_nxt = 1'b1;
          out_nxt       = reply_item(ev.reply_sel, 5'd0, ev.reply_id);
          busy_nxt      = 1'b1;
          pos_nxt       = 5'd1;
          sel_nxt       = ev.reply_sel;
          id_nxt        = ev.reply_id;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      pos_r       <= 5'd0;
      sel_r       <= REPLY_QUERY;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    id_r  <= id_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CSP_ASSERT_NOW(a_burst_shown, busy_r, out_valid_r, "reply burst without a presented item")
  `CSP_ASSERT_NOW(a_last_ends, out_valid_r && out_r.last, !busy_r && out_r.action == ACT_REPLY, "last flag inside a burst")
  `CSP_ASSERT_NOW(a_pos_bound, busy_r, pos_r <= reply_last_pos(sel_r), "reply position past end")

endmodule

FILE: rtl/control_surface_sysex_parser.sv
// ----------------------------------------------------------------------------
// control_surface_sysex_parser
// Control-surface SysEx parser: header and device ID match, command decode,
// display/meter actions and query replies.
// ----------------------------------------------------------------------------
// One input item is taken per cycle whenever the result register is free or
// being emptied in the same cycle, so in_ready follows out_ready. An item
// gives at most one action in the cycle after it is taken, except F7 closing
// a query command: that item starts a reply of 8, 12, 15 or 19 result items,
// produced one per cycle as out_ready allows, by the reply sequencer through
// the single result register; no input is taken until its last item is loaded.
// Configuration writes are taken in every cycle (cfg_ready is always high).
module control_surface_sysex_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csp_pkg::csp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csp_pkg::csp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import csp_pkg::*;

  csp_event_t ev;
  logic       take_ok;
  logic       item_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = take_ok;
  assign item_take = in_valid && take_ok;

  csp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .item_take (item_take),
    .item      (in_data),
    .ev        (ev)
  );

  csp_out_seq u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_take   (item_take),
    .ev        (ev),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
